// ----- rtl/core/otr_pkg.sv -----
`timescale 1ns / 1ps

package otr_pkg;

  // Request codes
  typedef enum logic [1:0] {
    OP_RECORD   = 2'd0,
    OP_SNAPSHOT = 2'd1,
    OP_CLEAR    = 2'd2,
    OP_UNUSED   = 2'd3
  } op_t;

  localparam int unsigned DEFAULT_RING_DEPTH = 32;

  localparam int unsigned TS_W    = 64;
  localparam int unsigned SEV_W   = 2;
  localparam int unsigned UNIT_W  = 3;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned DROP_W  = 32;

  localparam logic [SEV_W-1:0]  MAX_SEVERITY = 2'd2;
  localparam logic [KIND_W-1:0] MAX_KIND     = 4'd12;
  localparam logic [DROP_W-1:0] DROP_MAX     = {DROP_W{1'b1}};

  // One stored event
  typedef struct packed {
    logic [TS_W-1:0]   ts;
    logic [SEV_W-1:0]  sev;
    logic [UNIT_W-1:0] unit;
    logic [KIND_W-1:0] kind;
    logic [VAL_W-1:0]  val;
  } entry_t;

  // Response control, aligned with the ring read data
  typedef struct packed {
    logic strobe;
    logic accepted;
    logic has_event;
    logic last;
  } rsp_t;

endpackage

// ----- rtl/core/otr_mem.sv -----
`timescale 1ns / 1ps

module otr_mem #(
  parameter int unsigned RING_DEPTH = otr_pkg::DEFAULT_RING_DEPTH
) (
  input  logic                                                clk,
  input  logic                                                wr_en,
  input  logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] wr_addr,
  input  otr_pkg::entry_t                                     wr_data,
  input  logic [((RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1)-1:0] rd_addr,
  output otr_pkg::entry_t                                     rd_data
);

  otr_pkg::entry_t ring [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= ring[rd_addr];
  end

endmodule

// ----- rtl/core/otr_ctrl.sv -----
`timescale 1ns / 1ps

module otr_ctrl #(
  parameter int unsigned RING_DEPTH = otr_pkg::DEFAULT_RING_DEPTH,
  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       opcode,
  input  logic [otr_pkg::TS_W-1:0]         timestamp_ms,
  input  logic [otr_pkg::SEV_W-1:0]        severity,
  input  logic [otr_pkg::UNIT_W-1:0]       source_unit,
  input  logic [otr_pkg::KIND_W-1:0]       event_kind,
  input  logic [otr_pkg::VAL_W-1:0]        payload,
  output logic                             wr_en,
  output logic [IDX_W-1:0]                 wr_addr,
  output otr_pkg::entry_t                  wr_data,
  output logic [IDX_W-1:0]                 rd_addr,
  output otr_pkg::rsp_t                    rsp,
  output logic [CNT_W-1:0]                 rsp_count,
  output logic [otr_pkg::DROP_W-1:0]       rsp_drop
);

  localparam logic [CNT_W:0]   DEPTH_EXT = (CNT_W + 1)'(RING_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_SNAP
  } state_t;

  state_t                     state;
  logic [IDX_W-1:0]           oldest;
  logic [CNT_W-1:0]           count;
  logic [otr_pkg::DROP_W-1:0] dropped;
  logic [otr_pkg::TS_W-1:0]   newest_ts;
  logic [CNT_W-1:0]           snap_off;

  otr_pkg::op_t               op;
  logic                       accept;
  logic                       evt_ok;
  logic                       full;
  logic [otr_pkg::TS_W-1:0]   ts_stored;
  logic [CNT_W-1:0]           rd_off;

  // Ring position of the entry at a given offset from the oldest one
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + {1'b0, off};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign op     = otr_pkg::op_t'(opcode);
  assign busy   = (state == ST_SNAP);
  assign accept = start && !busy;
  assign full   = (count == DEPTH_CNT);
  assign evt_ok = (severity <= otr_pkg::MAX_SEVERITY) && (event_kind <= otr_pkg::MAX_KIND);

  // Hold timestamps monotonic against the newest held entry
  assign ts_stored = ((count != '0) && (timestamp_ms < newest_ts)) ? newest_ts : timestamp_ms;

  assign wr_en        = accept && (op == otr_pkg::OP_RECORD) && evt_ok;
  assign wr_addr      = slot_of(oldest, count);
  assign wr_data.ts   = ts_stored;
  assign wr_data.sev  = severity;
  assign wr_data.unit = source_unit;
  assign wr_data.kind = event_kind;
  assign wr_data.val  = payload;

  assign rd_off  = (state == ST_IDLE) ? '0 : snap_off;
  assign rd_addr = slot_of(oldest, rd_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      oldest     <= '0;
      count      <= '0;
      dropped    <= '0;
      snap_off   <= '0;
      rsp        <= '0;
      rsp_count  <= '0;
      rsp_drop   <= '0;
    end else begin
      rsp <= '0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            rsp.strobe <= 1'b1;
            rsp.last   <= 1'b1;
            rsp_count  <= count;
            rsp_drop   <= dropped;
            case (op)
              otr_pkg::OP_RECORD: begin
                rsp.accepted <= evt_ok;
                if (evt_ok) begin
                  newest_ts <= ts_stored;
                  if (full) begin
                    oldest <= slot_of(oldest, CNT_W'(1));
                    if (dropped != otr_pkg::DROP_MAX) begin
                      dropped  <= dropped + 1'b1;
                      rsp_drop <= dropped + 1'b1;
                    end
                  end else begin
                    count     <= count + 1'b1;
                    rsp_count <= count + 1'b1;
                  end
                end
              end
              otr_pkg::OP_SNAPSHOT: begin
                rsp.accepted <= 1'b1;
                if (count != '0) begin
                  rsp.has_event <= 1'b1;
                  rsp.last      <= (count == CNT_W'(1));
                  snap_off      <= CNT_W'(1);
                  if (count != CNT_W'(1)) begin
                    state <= ST_SNAP;
                  end
                end
              end
              otr_pkg::OP_CLEAR: begin
                rsp.accepted <= 1'b1;
                oldest       <= '0;
                count        <= '0;
                dropped      <= '0;
                rsp_count    <= '0;
                rsp_drop     <= '0;
              end
              default: begin
                rsp.accepted <= 1'b0;
              end
            endcase
          end
        end
        ST_SNAP: begin
          // Advance one held entry per cycle
          rsp.strobe    <= 1'b1;
          rsp.accepted  <= 1'b1;
          rsp.has_event <= 1'b1;
          rsp_count     <= count;
          rsp_drop      <= dropped;
          snap_off      <= snap_off + 1'b1;
          if (snap_off == count - 1'b1) begin
            rsp.last <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/overwriting_event_trace_ring_core.sv -----
`timescale 1ns / 1ps
// Channel   | Handshake               | Signals
// ----------+-------------------------+-----------------------------------------------
// request   | start, busy             | opcode, timestamp_ms, severity, source_unit,
//           |                         | event_kind, payload
// result    | result_strobe (1 cycle) | accepted, stored_count, drop_total, has_event,
//           |                         | out_timestamp_ms, out_severity, out_source_unit,
//           |                         | out_event_kind, out_payload, last_result
//
// A request is taken on a rising edge with start high and busy low. Record, clear
// and unused requests show their result in the next cycle while busy
// stays low, so records can arrive every cycle. A snapshot of N held events reads
// them oldest first, one ring read per cycle through the single read port, with
// each result in the cycle after its read; busy is high while the later reads issue.
// Synchronous reset empties the ring and zeroes the drop counter; the ring memory
// itself is not cleared since entries are only read after being written.
// The receiver cannot stall: each result is valid for exactly one cycle.

module overwriting_event_trace_ring_core #(
  parameter int unsigned RING_DEPTH = otr_pkg::DEFAULT_RING_DEPTH,
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode,
  input  logic [otr_pkg::TS_W-1:0]      timestamp_ms,
  input  logic [otr_pkg::SEV_W-1:0]     severity,
  input  logic [otr_pkg::UNIT_W-1:0]    source_unit,
  input  logic [otr_pkg::KIND_W-1:0]    event_kind,
  input  logic [otr_pkg::VAL_W-1:0]     payload,
  output logic                          result_strobe,
  output logic                          accepted,
  output logic [CNT_W-1:0]              stored_count,
  output logic [otr_pkg::DROP_W-1:0]    drop_total,
  output logic                          has_event,
  output logic [otr_pkg::TS_W-1:0]      out_timestamp_ms,
  output logic [otr_pkg::SEV_W-1:0]     out_severity,
  output logic [otr_pkg::UNIT_W-1:0]    out_source_unit,
  output logic [otr_pkg::KIND_W-1:0]    out_event_kind,
  output logic [otr_pkg::VAL_W-1:0]     out_payload,
  output logic                          last_result
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  otr_pkg::entry_t  wr_data;
  logic [IDX_W-1:0] rd_addr;
  otr_pkg::entry_t  rd_data;
  otr_pkg::rsp_t    rsp;

  // Pointers, counters and the snapshot sequencer
  otr_ctrl #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .timestamp_ms (timestamp_ms),
    .severity     (severity),
    .source_unit  (source_unit),
    .event_kind   (event_kind),
    .payload      (payload),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rsp          (rsp),
    .rsp_count    (stored_count),
    .rsp_drop     (drop_total)
  );

  // Event storage: one write port for records, one registered read port for snapshots
  otr_mem #(
    .RING_DEPTH (RING_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign result_strobe = rsp.strobe;
  assign accepted      = rsp.accepted;
  assign has_event     = rsp.has_event;
  assign last_result   = rsp.last;

  // Drop the stale read data on status-only results
  assign out_timestamp_ms = rsp.has_event ? rd_data.ts   : '0;
  assign out_severity     = rsp.has_event ? rd_data.sev  : '0;
  assign out_source_unit  = rsp.has_event ? rd_data.unit : '0;
  assign out_event_kind   = rsp.has_event ? rd_data.kind : '0;
  assign out_payload      = rsp.has_event ? rd_data.val  : '0;

endmodule

// ----- rtl/core/otr_checker.sv -----
`timescale 1ns / 1ps

module otr_checker #(
  parameter int unsigned RING_DEPTH = otr_pkg::DEFAULT_RING_DEPTH,
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1)
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          result_strobe,
  input logic                          accepted,
  input logic [CNT_W-1:0]              stored_count,
  input logic                          has_event,
  input logic                          last_result
);

  // Every taken request answers in the next cycle
  a_req_answers: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> result_strobe)
    else $error("taken request without result in the next cycle");

  // A snapshot stream runs without gaps until its final result
  a_stream_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_result) |=> (result_strobe && has_event))
    else $error("snapshot stream broken before its final result");

  // No new request is taken while more snapshot results are due
  a_busy_in_stream: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last_result) |-> busy)
    else $error("busy low while a snapshot is still streaming");

  // Event rows come only from a non-empty ring
  a_event_row: assert property (@(posedge clk) disable iff (rst)
    has_event |-> (result_strobe && accepted && (stored_count != '0)))
    else $error("event row without strobe or with an empty ring");

  // Status-only results are single
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !has_event) |-> last_result)
    else $error("status result not marked final");

endmodule

bind overwriting_event_trace_ring_core otr_checker #(
  .RING_DEPTH (RING_DEPTH)
) u_otr_checker (.*);

// ----- test/overwriting_event_trace_ring_core_tb.sv -----
`timescale 1ns / 1ps

module overwriting_event_trace_ring_core_tb;

  localparam int unsigned RING       = otr_pkg::DEFAULT_RING_DEPTH;
  localparam int unsigned N_RAND     = 450;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned TAIL_WAIT  = 48;

  // One request as the driver presents it
  typedef struct {
    otr_pkg::op_t    op;
    otr_pkg::entry_t ev;
    int unsigned     gap_pct;
    bit              wait_drain;
  } trace_req_t;

  // One result beat of the ring
  typedef struct {
    logic            acc;
    logic [5:0]      cnt;
    logic [31:0]     drop;
    logic            has;
    otr_pkg::entry_t ev;
    logic            last;
  } trace_out_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic [1:0]                   opcode = otr_pkg::OP_RECORD;
  logic [otr_pkg::TS_W-1:0]     timestamp_ms = '0;
  logic [otr_pkg::SEV_W-1:0]    severity = '0;
  logic [otr_pkg::UNIT_W-1:0]   source_unit = '0;
  logic [otr_pkg::KIND_W-1:0]   event_kind = '0;
  logic [otr_pkg::VAL_W-1:0]    payload = '0;
  logic                         result_strobe;
  logic                         accepted;
  logic [5:0]                   stored_count;
  logic [otr_pkg::DROP_W-1:0]   drop_total;
  logic                         has_event;
  logic [otr_pkg::TS_W-1:0]     out_timestamp_ms;
  logic [otr_pkg::SEV_W-1:0]    out_severity;
  logic [otr_pkg::UNIT_W-1:0]   out_source_unit;
  logic [otr_pkg::KIND_W-1:0]   out_event_kind;
  logic [otr_pkg::VAL_W-1:0]    out_payload;
  logic                         last_result;

  trace_req_t  req_queue[$];
  trace_out_t  trace_out_q[$];
  int unsigned taken_count = 0;
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;
  logic        take_seen = 1'b0;

  // Shadow copy of the ring
  otr_pkg::entry_t ring_mem [RING];
  int unsigned     ring_head = 0;
  int unsigned     ring_held = 0;
  logic [31:0]     ring_drops = '0;

  overwriting_event_trace_ring_core #(
    .RING_DEPTH(RING)
  ) i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // Status beat built from the shadow state; event fields zero, last set
  function automatic trace_out_t status_out(logic ok);
    trace_out_t o;
    o.acc  = ok;
    o.cnt  = ring_held[5:0];
    o.drop = ring_drops;
    o.has  = 1'b0;
    o.ev   = '0;
    o.last = 1'b1;
    return o;
  endfunction

  // Advance the shadow ring by one request and queue the beats it causes
  function automatic void apply_request(otr_pkg::op_t op, otr_pkg::entry_t ev);
    trace_out_t  o;
    int unsigned slot;
    case (op)
      otr_pkg::OP_RECORD: begin
        if (ev.sev > otr_pkg::MAX_SEVERITY || ev.kind > otr_pkg::MAX_KIND) begin
          // rejected: state untouched
          trace_out_q.push_back(status_out(1'b0));
        end else begin
          // never let time run backwards against the newest held entry
          if (ring_held != 0) begin
            slot = (ring_head + ring_held - 1) % RING;
            if (ev.ts < ring_mem[slot].ts) ev.ts = ring_mem[slot].ts;
          end
          ring_mem[(ring_head + ring_held) % RING] = ev;
          if (ring_held < RING) begin
            ring_held++;
          end else begin
            // full: drop the oldest and count it, saturating
            ring_head = (ring_head + 1) % RING;
            if (ring_drops != otr_pkg::DROP_MAX) ring_drops++;
          end
          trace_out_q.push_back(status_out(1'b1));
        end
      end
      otr_pkg::OP_SNAPSHOT: begin
        if (ring_held == 0) begin
          trace_out_q.push_back(status_out(1'b1));
        end else begin
          // oldest first, last flag only on the final beat
          for (int unsigned i = 0; i < ring_held; i++) begin
            o      = status_out(1'b1);
            o.has  = 1'b1;
            o.ev   = ring_mem[(ring_head + i) % RING];
            o.last = (i + 1 == ring_held);
            trace_out_q.push_back(o);
          end
        end
      end
      otr_pkg::OP_CLEAR: begin
        ring_head  = 0;
        ring_held  = 0;
        ring_drops = '0;
        trace_out_q.push_back(status_out(1'b1));
      end
      default: begin
        trace_out_q.push_back(status_out(1'b0));
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  task automatic add_req(otr_pkg::op_t op, logic [63:0] ts, logic [1:0] sev,
                         logic [2:0] unit, logic [3:0] kind, logic [31:0] val);
    trace_req_t r;
    r.op         = op;
    r.ev         = '{ts: ts, sev: sev, unit: unit, kind: kind, val: val};
    r.gap_pct    = 0;
    r.wait_drain = 1'b0;
    req_queue.push_back(r);
  endtask

  // Driver: present requests at the falling edge, hold until taken
  always @(negedge clk) begin
    trace_req_t nxt;
    bit         go;
    go = 1'b0;
    if (!rst && (!start || take_seen)) begin
      if (req_queue.size() != 0) begin
        nxt = req_queue[0];
        // pause for a full drain where asked, otherwise idle at random
        if (!(nxt.wait_drain && trace_out_q.size() != 0) &&
            $urandom_range(99) >= nxt.gap_pct) begin
          go = 1'b1;
          void'(req_queue.pop_front());
        end
      end
      start <= go;
      if (go) begin
        opcode       <= nxt.op;
        timestamp_ms <= nxt.ev.ts;
        severity     <= nxt.ev.sev;
        source_unit  <= nxt.ev.unit;
        event_kind   <= nxt.ev.kind;
        payload      <= nxt.ev.val;
      end
    end
  end

  // Monitor: check result beats, predict on each taken request, watch for a hang
  always @(posedge clk) begin
    trace_out_t      want;
    otr_pkg::entry_t ev;
    if (!rst) begin
      if (result_strobe) begin
        if (trace_out_q.size() == 0) begin
          errors++;
          $error("result beat with nothing outstanding");
        end else begin
          want = trace_out_q.pop_front();
          check_field("accepted", want.acc, accepted);
          check_field("stored_count", want.cnt, stored_count);
          check_field("drop_total", want.drop, drop_total);
          check_field("has_event", want.has, has_event);
          check_field("out_timestamp_ms", want.ev.ts, out_timestamp_ms);
          check_field("out_severity", want.ev.sev, out_severity);
          check_field("out_source_unit", want.ev.unit, out_source_unit);
          check_field("out_event_kind", want.ev.kind, out_event_kind);
          check_field("out_payload", want.ev.val, out_payload);
          check_field("last_result", want.last, last_result);
        end
      end
      // predict from what was actually on the request ports
      if (start && !busy) begin
        ev = '{ts: timestamp_ms, sev: severity, unit: source_unit, kind: event_kind,
               val: payload};
        apply_request(otr_pkg::op_t'(opcode), ev);
        taken_count++;
      end
      take_seen <= start && !busy;
      if (result_strobe || (start && !busy)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_MAX) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [63:0] ts_base;
    logic [63:0] ts;
    logic [1:0]  sev;
    logic [3:0]  kind;
    int unsigned n;
    int unsigned r;
    int unsigned t;
    int unsigned total;

    // Directed: empty readout, field extremes, rejects, unused code,
    // time raise, clear and the empty ring after it
    add_req(otr_pkg::OP_SNAPSHOT, '1, 2'd3, 3'd7, 4'd15, '1);
    add_req(otr_pkg::OP_RECORD, '0, 2'd0, 3'd0, 4'd0, '0);
    add_req(otr_pkg::OP_RECORD, '1, 2'd2, 3'd7, 4'd12, '1);
    add_req(otr_pkg::OP_RECORD, 64'd5, 2'd1, 3'd3, 4'd7, 32'h1234_5678);
    add_req(otr_pkg::OP_RECORD, 64'd9, 2'd3, 3'd1, 4'd0, 32'h0000_00aa);
    add_req(otr_pkg::OP_RECORD, 64'd9, 2'd0, 3'd2, 4'd13, 32'h0000_00bb);
    add_req(otr_pkg::OP_RECORD, 64'd9, 2'd3, 3'd5, 4'd15, 32'h0000_00cc);
    add_req(otr_pkg::OP_UNUSED, '0, 2'd0, 3'd0, 4'd0, '0);
    add_req(otr_pkg::OP_SNAPSHOT, '0, 2'd0, 3'd0, 4'd0, '0);
    add_req(otr_pkg::OP_CLEAR, '1, 2'd3, 3'd7, 4'd15, '1);
    add_req(otr_pkg::OP_SNAPSHOT, '0, 2'd0, 3'd0, 4'd0, '0);
    add_req(otr_pkg::OP_RECORD, 64'd100, 2'd2, 3'd4, 4'd1, 32'h8000_0001);
    add_req(otr_pkg::OP_RECORD, 64'd50, 2'd1, 3'd6, 4'd11, 32'h7fff_fffe);
    add_req(otr_pkg::OP_SNAPSHOT, '0, 2'd0, 3'd0, 4'd0, '0);
    add_req(otr_pkg::OP_UNUSED, '1, 2'd3, 3'd7, 4'd15, '1);
    add_req(otr_pkg::OP_CLEAR, '0, 2'd0, 3'd0, 4'd0, '0);

    // Random: mostly bursts of well-formed records between readouts, so the
    // ring fills and wraps; clears, unused codes and junk records mixed in
    ts_base = 64'd1000;
    while (req_queue.size() < N_RAND) begin
      r = $urandom_range(99);
      if (r < 65) begin
        n = $urandom_range(1, 40);
        repeat (n) begin
          t = $urandom_range(99);
          if (t < 75) begin
            ts_base += $urandom_range(0, 1000);
            ts = ts_base;
          end else if (t < 90) begin
            ts = ts_base - $urandom_range(1, 500);
          end else begin
            ts = {$urandom, $urandom};
          end
          sev  = ($urandom_range(99) < 90) ? 2'($urandom_range(2)) : 2'd3;
          kind = ($urandom_range(99) < 90) ? 4'($urandom_range(12))
                                           : 4'($urandom_range(13, 15));
          add_req(otr_pkg::OP_RECORD, ts, sev, 3'($urandom_range(7)), kind, $urandom);
        end
      end else if (r < 80) begin
        add_req(otr_pkg::OP_SNAPSHOT, {$urandom, $urandom}, 2'($urandom_range(3)),
                3'($urandom_range(7)), 4'($urandom_range(15)), $urandom);
      end else if (r < 90) begin
        add_req(otr_pkg::OP_CLEAR, {$urandom, $urandom}, 2'($urandom_range(3)),
                3'($urandom_range(7)), 4'($urandom_range(15)), $urandom);
        ts_base = 64'($urandom_range(0, 100000));
      end else if (r < 95) begin
        add_req(otr_pkg::OP_UNUSED, {$urandom, $urandom}, 2'($urandom_range(3)),
                3'($urandom_range(7)), 4'($urandom_range(15)), $urandom);
      end else begin
        add_req(otr_pkg::OP_RECORD, {$urandom, $urandom}, 2'($urandom_range(3)),
                3'($urandom_range(7)), 4'($urandom_range(15)), $urandom);
      end
    end

    // Sender idle rate per third of the run; drain pauses sprinkled through
    total = req_queue.size();
    foreach (req_queue[i]) begin
      if (i < total / 3) req_queue[i].gap_pct = 37;
      else if (i < 2 * total / 3) req_queue[i].gap_pct = 65;
      else req_queue[i].gap_pct = 0;
      if (i == 13 || (i % 75) == 40) req_queue[i].wait_drain = 1'b1;
    end

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Wait for every request to be taken and every beat to come back
    while (taken_count != total || trace_out_q.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);

    if (errors == 0 && trace_out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/otr_pkg.sv
rtl/core/otr_mem.sv
rtl/core/otr_ctrl.sv
rtl/core/overwriting_event_trace_ring_core.sv
rtl/core/otr_checker.sv
test/overwriting_event_trace_ring_core_tb.sv
